// ===== rtl/assert_macros.svh =====
// Assertion macros for the port-level checker.
// Include guard keeps repeated inclusion harmless.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock edge, reset disables.
`define SSKP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, reset disables.
`define SSKP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/sskp_pkg.sv =====
// Package for the sticky slot key pool: sizes, codes, state type, helpers.
// No dependencies.
package sskp_pkg;
  localparam int SlotCount = 8;
  localparam int KeyBytes  = 8;
  localparam int SlotW     = (SlotCount > 1) ? $clog2(SlotCount) : 1;
  localparam int CntW      = $clog2(SlotCount + 1);
  localparam int KeyW      = 64;

  localparam logic [1:0] KindAdd    = 2'd0;
  localparam logic [1:0] KindCommit = 2'd1;
  localparam logic [1:0] KindQuery  = 2'd2;

  typedef enum logic [2:0] {
    StIdle, StScan, StFree, StPick, StPlace, StCount, StDone
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_item;   // capture input item, clear pointer
    logic ptr_clr;
    logic ptr_inc;
    logic best_clr;
    logic add_scan;    // append held key to scan list
    logic free_step;   // free slot[ptr] if absent from scan
    logic pick_step;   // consider scan[ptr] as best candidate
    logic place;       // write best key into lowest free slot
    logic count_step;  // count scan[ptr] if unplaced
    logic query_step;  // compare slot[ptr] with held key
    logic finish;      // load result register
    logic scan_reset;
  } sskp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [1:0] kind;
    logic       ptr_last;   // pointer at final entry
    logic       scan_dup;   // held key already in scan list
    logic       key_zero;
    logic       scan_full;
    logic       scan_empty;
    logic       have_best;
    logic       have_free;
  } sskp_sts_t;

  // Keep the first KeyBytes bytes up to the first zero byte.
  function automatic logic [KeyW-1:0] key_norm(input logic [KeyW-1:0] v);
    logic [KeyW-1:0] r;
    logic            stop;
    r    = '0;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (i >= KeyBytes || v[56-8*i +: 8] == 8'd0) stop = 1'b1;
      if (!stop) r[56-8*i +: 8] = v[56-8*i +: 8];
    end
    return r;
  endfunction
endpackage

// ===== rtl/sskp_if.sv =====
// Valid/ready channel interfaces for the sticky slot key pool.
// Depends on sskp_pkg.
interface sskp_in_if import sskp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [1:0]      kind;
  logic [KeyW-1:0] key_value;
  modport source (output valid, kind, key_value, input ready);
  modport sink (input valid, kind, key_value, output ready);
endinterface

interface sskp_out_if import sskp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       found;
  logic [2:0] slot_index;
  logic [3:0] unassigned_count;
  modport source (output valid, found, slot_index, unassigned_count, input ready);
  modport sink (input valid, found, slot_index, unassigned_count, output ready);
endinterface

// ===== rtl/sskp_ctrl.sv =====
// Controller state machine of the sticky slot key pool.
// Depends on sskp_pkg.
module sskp_ctrl import sskp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      res_busy_i,
  input  sskp_sts_t sts_i,
  output sskp_cmd_t cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_valid_i && !res_busy_i) state_d = StScan;
      StScan: begin
        case (sts_i.kind)
          KindAdd:    state_d = (sts_i.ptr_last || sts_i.scan_empty) ? StDone : StScan;
          KindCommit: state_d = sts_i.ptr_last ? StFree : StScan;
          KindQuery:  state_d = sts_i.ptr_last ? StDone : StScan;
          default:    state_d = StDone;
        endcase
      end
      StFree:  state_d = StPick;
      StPick:  if (sts_i.ptr_last) state_d = StPlace;
      StPlace: state_d = (sts_i.have_best && sts_i.have_free) ? StPick : StCount;
      StCount: if (sts_i.ptr_last) state_d = StDone;
      StDone:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o     = !res_busy_i;
        cmd_o.load_item = in_valid_i && !res_busy_i;
      end
      StScan: begin
        case (sts_i.kind)
          KindAdd: begin
            // Walk the list for duplicates, append at the end.
            if (sts_i.ptr_last || sts_i.scan_empty)
              cmd_o.add_scan = !sts_i.key_zero && !sts_i.scan_full && !sts_i.scan_dup;
            cmd_o.ptr_inc = 1'b1;
          end
          KindCommit: begin
            cmd_o.free_step = 1'b1;
            cmd_o.ptr_inc   = 1'b1;
          end
          KindQuery: begin
            cmd_o.query_step = 1'b1;
            cmd_o.ptr_inc    = 1'b1;
          end
          default: ;
        endcase
      end
      StFree: begin
        cmd_o.ptr_clr  = 1'b1;
        cmd_o.best_clr = 1'b1;
      end
      StPick: begin
        cmd_o.pick_step = 1'b1;
        cmd_o.ptr_inc   = 1'b1;
      end
      StPlace: begin
        cmd_o.place    = sts_i.have_best && sts_i.have_free;
        cmd_o.ptr_clr  = 1'b1;
        cmd_o.best_clr = 1'b1;
      end
      StCount: begin
        cmd_o.count_step = 1'b1;
        cmd_o.ptr_inc    = 1'b1;
      end
      StDone: begin
        cmd_o.finish     = 1'b1;
        cmd_o.scan_reset = (sts_i.kind == KindCommit);
      end
      default: ;
    endcase
  end
endmodule

// ===== rtl/sskp_dp.sv =====
// Datapath of the sticky slot key pool: slot table, scan list, walk pointer,
// best-key tracker and result register. Depends on sskp_pkg.
module sskp_dp import sskp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [1:0]      kind_i,
  input  logic [KeyW-1:0] key_i,
  input  sskp_cmd_t       cmd_i,
  output sskp_sts_t       sts_o,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output logic            found_o,
  output logic [2:0]      slot_index_o,
  output logic [3:0]      unassigned_o
);
  logic [KeyW-1:0] slot_q [SlotCount];
  logic [KeyW-1:0] scan_q [SlotCount];
  logic [CntW-1:0] scan_cnt_q;
  logic [SlotW-1:0] ptr_q;
  logic [1:0]      kind_q;
  logic [KeyW-1:0] key_q;
  logic [KeyW-1:0] best_q;
  logic            have_best_q;
  logic            dup_q;
  logic            found_q;
  logic [SlotW-1:0] idx_q;
  logic [CntW-1:0] left_q;
  logic            res_valid_q;
  logic            res_found_q;
  logic [2:0]      res_idx_q;
  logic [3:0]      res_left_q;

  logic [KeyW-1:0] scan_cur, slot_cur;
  logic            in_scan_cur;   // slot[ptr] present in scan list
  logic            placed_cur;    // scan[ptr] holds a slot
  logic            have_free;
  logic [SlotW-1:0] free_idx;

  assign scan_cur    = scan_q[ptr_q];
  assign slot_cur    = slot_q[ptr_q];

  always_comb begin
    in_scan_cur = 1'b0;
    placed_cur  = 1'b0;
    have_free   = 1'b0;
    free_idx    = '0;
    for (int j = 0; j < SlotCount; j++) begin
      if (CntW'(j) < scan_cnt_q && scan_q[j] == slot_cur) in_scan_cur = 1'b1;
      if (slot_q[j] == scan_cur) placed_cur = 1'b1;
    end
    for (int j = SlotCount - 1; j >= 0; j--) begin
      if (slot_q[j] == '0) begin
        have_free = 1'b1;
        free_idx  = SlotW'(j);
      end
    end
  end

  logic scan_valid_cur;
  assign scan_valid_cur = CntW'(ptr_q) < scan_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < SlotCount; j++) slot_q[j] <= '0;
      scan_cnt_q  <= '0;
      ptr_q       <= '0;
      res_valid_q <= 1'b0;
      kind_q      <= '0;
    end else begin
      if (cmd_i.load_item) begin
        kind_q <= kind_i;
        ptr_q  <= '0;
      end else if (cmd_i.ptr_clr) begin
        ptr_q <= '0;
      end else if (cmd_i.ptr_inc) begin
        ptr_q <= ptr_q + 1'b1;
      end
      if (cmd_i.add_scan) scan_cnt_q <= scan_cnt_q + 1'b1;
      if (cmd_i.scan_reset) scan_cnt_q <= '0;
      if (cmd_i.free_step && slot_cur != '0 && !in_scan_cur) slot_q[ptr_q] <= '0;
      if (cmd_i.place) slot_q[free_idx] <= best_q;
      if (cmd_i.finish) res_valid_q <= 1'b1;
      else if (res_ready_i) res_valid_q <= 1'b0;
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      key_q   <= key_norm(key_i);
      dup_q   <= 1'b0;
      found_q <= 1'b0;
      idx_q   <= '0;
      left_q  <= '0;
    end
    if (cmd_i.add_scan) scan_q[scan_cnt_q[SlotW-1:0]] <= key_q;
    if (kind_q == KindAdd && cmd_i.ptr_inc && scan_valid_cur && scan_cur == key_q)
      dup_q <= 1'b1;
    if (cmd_i.best_clr) have_best_q <= 1'b0;
    if (cmd_i.pick_step && scan_valid_cur && !placed_cur &&
        (!have_best_q || scan_cur < best_q)) begin
      best_q      <= scan_cur;
      have_best_q <= 1'b1;
    end
    if (cmd_i.count_step && scan_valid_cur && !placed_cur) left_q <= left_q + 1'b1;
    if (cmd_i.query_step && !found_q && key_q != '0 && slot_cur == key_q) begin
      found_q <= 1'b1;
      idx_q   <= ptr_q;
    end
    if (cmd_i.finish) begin
      res_found_q <= found_q && kind_q == KindQuery;
      res_idx_q   <= (found_q && kind_q == KindQuery) ? 3'(idx_q) : 3'd0;
      res_left_q  <= (kind_q == KindCommit) ? 4'(left_q) : 4'd0;
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.kind       = kind_q;
    sts_o.ptr_last   = (ptr_q == SlotW'(SlotCount - 1)) || (SlotCount == 1);
    sts_o.scan_dup   = dup_q || (scan_valid_cur && scan_cur == key_q);
    sts_o.key_zero   = (key_q == '0);
    sts_o.scan_full  = (scan_cnt_q >= CntW'(SlotCount));
    sts_o.scan_empty = (scan_cnt_q == '0) || (CntW'(ptr_q) + 1'b1 >= scan_cnt_q);
    sts_o.have_best  = have_best_q;
    sts_o.have_free  = have_free;
  end

  assign res_valid_o  = res_valid_q;
  assign found_o      = res_found_q;
  assign slot_index_o = res_idx_q;
  assign unassigned_o = res_left_q;
endmodule

// ===== rtl/sticky_slot_key_pool.sv =====
// Sticky slot key pool: keys hold small slot indices across rescans.
// Add walks the scan list, query walks the slot table; commit frees, then picks and places keys, then counts.
// One item at a time; the slot walks step over all eight entries.
// A new item is taken only once the controller is idle and the last result has been transferred.
// Reset (rst_ni low, asynchronous) frees all slots and empties the scan list.
// Depends on sskp_pkg, sskp_if, sskp_ctrl and sskp_dp.
module sticky_slot_key_pool import sskp_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  sskp_in_if.sink   in_i,
  sskp_out_if.source out_o
);
  sskp_cmd_t cmd;
  sskp_sts_t sts;
  logic      res_valid;

  // Controller: sequences each item through the walks.
  sskp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .res_busy_i (res_valid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: tables, pointer and result register; hold result until transfer.
  sskp_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .kind_i       (in_i.kind),
    .key_i        (in_i.key_value),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .res_valid_o  (res_valid),
    .res_ready_i  (out_o.ready),
    .found_o      (out_o.found),
    .slot_index_o (out_o.slot_index),
    .unassigned_o (out_o.unassigned_count)
  );

  assign out_o.valid = res_valid;
endmodule

// ===== rtl/sskp_checker.sv =====
// Port-level checker for the sticky slot key pool, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module sskp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       found,
  input logic [2:0] slot_index,
  input logic [3:0] unassigned_count
);
  `SSKP_ASSERT_IMP(a_idx_zero, clk_i, rst_ni, out_valid && !found, slot_index == 3'd0, "index without hit")
  `SSKP_ASSERT_IMP(a_excl, clk_i, rst_ni, out_valid && found, unassigned_count == 4'd0, "mixed result")
  `SSKP_ASSERT_NXT(a_no_out_next, clk_i, rst_ni, in_valid && in_ready, !out_valid, "result too early")
  `SSKP_ASSERT_IMP(a_busy, clk_i, rst_ni, out_valid, !in_ready, "accept while result pending")
endmodule

bind sticky_slot_key_pool sskp_checker u_sskp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid         (in_i.valid),
  .in_ready         (in_i.ready),
  .out_valid        (out_o.valid),
  .out_ready        (out_o.ready),
  .found            (out_o.found),
  .slot_index       (out_o.slot_index),
  .unassigned_count (out_o.unassigned_count)
);

// ===== tb/sticky_slot_key_pool_tb.sv =====
// Testbench for the sticky slot key pool: drives scans, commits and queries,
// predicts every result in place and compares transfers field by field.
// Depends on sskp_pkg, sskp_if and the sticky_slot_key_pool RTL.
module sticky_slot_key_pool_tb;
  import sskp_pkg::*;

  typedef struct packed {
    logic [1:0]      kind;
    logic [KeyW-1:0] key_value;
  } item_t;

  typedef struct packed {
    logic       found;
    logic [2:0] slot_index;
    logic [3:0] unassigned_count;
  } outcome_t;

  localparam int StallLimit = 20000;

  logic clk_i;
  logic rst_ni;

  sskp_in_if  in_ch ();
  sskp_out_if out_ch ();

  sticky_slot_key_pool dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  // Predictor state: slot table and the scan list under construction.
  logic [KeyW-1:0] pred_slots [SlotCount];
  logic [KeyW-1:0] pred_scan [SlotCount];
  int              pred_scan_n;

  item_t    pending_items [$];
  outcome_t awaited [$];
  int       mismatches;
  int       idle_cycles;
  bit       quiet_phase;

  // Keep leading non-zero bytes within the key length; clear the rest.
  function automatic logic [KeyW-1:0] trim_key(logic [KeyW-1:0] v);
    logic [KeyW-1:0] r;
    bit              stop;
    r    = '0;
    stop = 0;
    for (int i = 0; i < 8; i++) begin
      if (i >= KeyBytes || v[56-8*i +: 8] == 8'd0) stop = 1;
      if (!stop) r[56-8*i +: 8] = v[56-8*i +: 8];
    end
    return r;
  endfunction

  function automatic int slot_holding(logic [KeyW-1:0] k);
    if (k == '0) return -1;
    for (int i = 0; i < SlotCount; i++) if (pred_slots[i] == k) return i;
    return -1;
  endfunction

  function automatic bit scanned(logic [KeyW-1:0] k);
    for (int j = 0; j < pred_scan_n; j++) if (pred_scan[j] == k) return 1;
    return 0;
  endfunction

  // Advance the predictor by one item and return the result it causes.
  function automatic outcome_t predict_outcome(item_t it);
    outcome_t        o;
    logic [KeyW-1:0] k;
    logic [KeyW-1:0] best;
    bit              have;
    int              free_at;
    int              s;
    o = '0;
    k = trim_key(it.key_value);
    case (it.kind)
      KindAdd: begin
        if (k != '0 && pred_scan_n < SlotCount && !scanned(k)) begin
          pred_scan[pred_scan_n] = k;
          pred_scan_n++;
        end
      end
      KindCommit: begin
        // Free slots whose key left the scan.
        for (int i = 0; i < SlotCount; i++)
          if (pred_slots[i] != '0 && !scanned(pred_slots[i])) pred_slots[i] = '0;
        // Place new keys, smallest first, into the lowest free slots.
        forever begin
          have    = 0;
          best    = '0;
          free_at = -1;
          for (int j = 0; j < pred_scan_n; j++)
            if (slot_holding(pred_scan[j]) < 0 && (!have || pred_scan[j] < best)) begin
              best = pred_scan[j];
              have = 1;
            end
          if (!have) break;
          for (int i = SlotCount - 1; i >= 0; i--) if (pred_slots[i] == '0) free_at = i;
          if (free_at < 0) break;
          pred_slots[free_at] = best;
        end
        for (int j = 0; j < pred_scan_n; j++)
          if (slot_holding(pred_scan[j]) < 0) o.unassigned_count++;
        pred_scan_n = 0;
      end
      KindQuery: begin
        s = slot_holding(k);
        if (s >= 0) begin
          o.found      = 1'b1;
          o.slot_index = s[2:0];
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // Keys from a small pool so that scans overlap and keys stick.
  function automatic logic [KeyW-1:0] pool_key();
    logic [KeyW-1:0] k;
    k = {8'h41 + 8'($urandom_range(0, 11)), 8'h30 + 8'($urandom_range(0, 3)), 48'h0};
    if ($urandom_range(0, 3) == 0) k[47:40] = 8'($urandom_range(1, 255));
    return k;
  endfunction

  function automatic logic [KeyW-1:0] wild_key();
    return {$urandom, $urandom};
  endfunction

  task automatic push(logic [1:0] kind, logic [KeyW-1:0] key);
    item_t it;
    it.kind      = kind;
    it.key_value = key;
    pending_items.push_back(it);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Driver: present the head of the queue, dropping it once transferred.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid     <= 1'b0;
      in_ch.kind      <= KindAdd;
      in_ch.key_value <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        awaited.push_back(predict_outcome(item_t'{in_ch.kind, in_ch.key_value}));
        void'(pending_items.pop_front());
      end
      if (pending_items.size() > 0 && (quiet_phase || $urandom_range(0, 99) >= 9)) begin
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= pending_items[0].kind;
        in_ch.key_value <= pending_items[0].key_value;
      end else if (!(in_ch.valid && !in_ch.ready)) begin
        // Hold a valid that has not been taken; otherwise idle.
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: compare every result transfer with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      idle_cycles  <= 0;
    end else begin
      out_ch.ready <= quiet_phase || $urandom_range(0, 99) >= 9;
      if (out_ch.valid && out_ch.ready) begin
        if (awaited.size() == 0) begin
          report_mismatch("unexpected result", 64'd0, 64'd0);
        end else begin
          want = awaited.pop_front();
          if (out_ch.found !== want.found)
            report_mismatch("found", 64'(out_ch.found), 64'(want.found));
          if (out_ch.slot_index !== want.slot_index)
            report_mismatch("slot_index", 64'(out_ch.slot_index), 64'(want.slot_index));
          if (out_ch.unassigned_count !== want.unassigned_count)
            report_mismatch("unassigned_count", 64'(out_ch.unassigned_count),
                            64'(want.unassigned_count));
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk_i) begin
    if (idle_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int n;
    int q;
    mismatches  = 0;
    quiet_phase = 0;
    pred_scan_n = 0;
    for (int i = 0; i < SlotCount; i++) begin
      pred_slots[i] = '0;
      pred_scan[i]  = '0;
    end
    in_ch.valid     = 1'b0;
    in_ch.kind      = KindAdd;
    in_ch.key_value = '0;
    out_ch.ready    = 1'b0;
    rst_ni          = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty keys, extremes, duplicates, overflow, kind 3, empty commit.
    push(KindQuery, '0);
    push(KindAdd, '0);
    push(KindAdd, 64'hFFFF_FFFF_FFFF_FFFF);
    push(KindAdd, 64'h0100_0000_0000_0000);
    push(KindAdd, 64'h4100_FF00_0000_0001);
    push(KindAdd, 64'hFFFF_FFFF_FFFF_FFFF);
    push(KindAdd, 64'h00FF_FFFF_FFFF_FFFF);
    push(KindCommit, '0);
    push(KindQuery, 64'h4100_0000_0000_0000);
    push(KindQuery, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int i = 0; i < 10; i++) push(KindAdd, {8'h50 + 8'(i), 56'h0});
    push(KindCommit, 64'hFFFF_FFFF_FFFF_FFFF);
    push(KindQuery, {8'h57, 56'h0});
    push(2'd3, 64'h5000_0000_0000_0000);
    push(KindCommit, '0);
    push(KindQuery, 64'h5000_0000_0000_0000);

    // Random: mostly well-formed scans with overlapping keys, then noise.
    n = 0;
    while (n < 1250) begin
      if ($urandom_range(0, 5) != 0) begin
        repeat ($urandom_range(0, 11)) begin
          push(KindAdd, ($urandom_range(0, 9) == 0) ? wild_key() : pool_key());
          n++;
        end
        push(KindCommit, wild_key());
        q = $urandom_range(1, 4);
        repeat (q) push(KindQuery, pool_key());
        n += 1 + q;
      end else begin
        push(2'($urandom_range(0, 3)), ($urandom_range(0, 1)) ? wild_key() : pool_key());
        n++;
      end
      // A stretch without idling on either side.
      if (n > 500 && n < 700) quiet_phase = 1;
      else quiet_phase = 0;
      wait (pending_items.size() < 4);
    end
    wait (pending_items.size() == 0 && !in_ch.valid);
    wait (awaited.size() == 0);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && awaited.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sskp_pkg.sv
rtl/sskp_if.sv
rtl/sskp_ctrl.sv
rtl/sskp_dp.sv
rtl/sticky_slot_key_pool.sv
rtl/sskp_checker.sv
tb/sticky_slot_key_pool_tb.sv
